>>> design/crs_pkg.sv
// Package: shared types, constants and codes of the cumulative redundant input sender.
package crs_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int MAX_INPUTS    = 32;
    localparam int HEADER_BYTES  = 24;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(MAX_INPUTS + 1);

    localparam logic [1:0] ACT_RECORD  = 2'd0;
    localparam logic [1:0] ACT_SEND    = 2'd1;
    localparam logic [1:0] ACT_RECEIVE = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_ANSWER = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BUF_SMALL = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BAD_PHASE = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;

    localparam logic [1:0] REG_SESSION = 2'd0;
    localparam logic [1:0] REG_BUFFER  = 2'd1;
    localparam logic [1:0] REG_MAGIC   = 2'd2;
    localparam logic [1:0] REG_PHASE   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_PLAN, S_OUT, S_READ, S_WORD
    } crs_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] frame_number;
        logic [15:0] input_word;
        logic [7:0]  desync_byte;
        logic [31:0] timing_value;
        logic [31:0] pkt_magic;
        logic [7:0]  pkt_phase;
        logic [31:0] pkt_frame;
        logic [31:0] pkt_last_confirmed;
        logic [7:0]  pkt_input_count;
        logic [15:0] pkt_length;
    } crs_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] frame_out;
        logic [31:0] confirm_out;
        logic [7:0]  count_out;
        logic [15:0] word_out;
        logic [15:0] session_out;
        logic [7:0]  desync_out;
        logic [31:0] timing_out;
        logic        confirmed_flag;
        logic        last;
    } crs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic exec;      // record / receive / compute send plan
        logic plan;      // compute count and buffer check
        logic head;      // build first result
        logic rd;        // issue history read for current index
        logic word;      // build word result from read data
        logic adv;       // step to older frame
    } crs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       send_abort;   // buffer below a header
        logic       send_err;     // packet over the buffer
        logic       more;         // words remain to send
    } crs_sts_t;

endpackage

>>> design/crs_datapath.sv
// Datapath: history ring, marks, send planning, receive checks and result build.
module crs_datapath import crs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  crs_cmd_t    cmd,
    output crs_sts_t    sts,
    input  crs_in_t     in_item,
    input  logic [15:0] session_tag,
    input  logic [15:0] buffer_bytes,
    input  logic [31:0] expected_magic,
    input  logic [7:0]  gameplay_phase,
    output crs_out_t    res
);

    logic [15:0] words_mem [HISTORY_DEPTH];
    logic [31:0] tags_mem  [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] vld_reg;

    crs_in_t     item_reg;
    logic [31:0] newest_reg, oldest_reg, peer_reg, recv_reg, sent_reg;
    logic [31:0] start_reg;
    logic [CNT_W-1:0] count_reg, idx_reg;
    logic        err_reg;
    logic [15:0] rd_word_reg;
    logic [31:0] rd_tag_reg;
    logic        rd_vld_reg;
    logic [31:0] rd_frame_reg;

    logic [31:0] frame, rd_frame, start_c, diff, oldest_upd;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] cnt_c;
    logic [17:0] need;
    logic [2:0]  rstat;
    logic [8:0]  need_cnt;
    logic [16:0] rneed;
    crs_out_t    res_next;

    assign frame    = item_reg.frame_number;
    assign slot     = frame[SLOT_W-1:0];
    assign rd_frame = frame - 32'(idx_reg);

    // oldest held frame once the current frame is recorded
    always_comb begin
        if (oldest_reg == 32'd0)
            oldest_upd = frame;
        else if (frame >= 32'(HISTORY_DEPTH))
            oldest_upd = frame - 32'(HISTORY_DEPTH) + 32'd1;
        else
            oldest_upd = oldest_reg;
    end

    always_comb begin
        start_c = peer_reg + 32'd1;
        if (start_c < 32'd1) start_c = 32'd1;
        if (start_c < oldest_upd) start_c = oldest_upd;
    end

    assign diff  = frame - start_reg;
    assign cnt_c = (frame < start_reg) ? '0 :
                   (diff >= 32'(MAX_INPUTS - 1)) ? CNT_W'(MAX_INPUTS) : CNT_W'(diff + 32'd1);
    assign need  = 18'(HEADER_BYTES) + {17'd0, 1'b0} + 18'({cnt_c, 1'b0});

    always_comb begin
        need_cnt = {item_reg.pkt_input_count, 1'b0};
        rneed    = 17'(HEADER_BYTES) + {8'd0, need_cnt};
        if (item_reg.pkt_length < 16'(HEADER_BYTES))            rstat = ST_SHORT;
        else if (item_reg.pkt_magic != expected_magic)          rstat = ST_BAD_MAGIC;
        else if (item_reg.pkt_phase != gameplay_phase)          rstat = ST_BAD_PHASE;
        else if ({1'b0, item_reg.pkt_length} < rneed)           rstat = ST_SHORT;
        else if (item_reg.pkt_input_count > 8'(MAX_INPUTS))     rstat = ST_TOO_MANY;
        else                                                    rstat = ST_OK;
    end

    assign sts.action     = item_reg.action;
    assign sts.send_abort = buffer_bytes < 16'(HEADER_BYTES);
    assign sts.send_err   = err_reg;
    assign sts.more       = idx_reg < count_reg;

    // history ring, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.exec && (item_reg.action == ACT_RECORD ||
                         (item_reg.action == ACT_SEND && !sts.send_abort))) begin
            words_mem[slot] <= item_reg.input_word;
            tags_mem[slot]  <= frame;
        end
        if (cmd.rd) begin
            rd_word_reg  <= words_mem[rd_frame[SLOT_W-1:0]];
            rd_tag_reg   <= tags_mem[rd_frame[SLOT_W-1:0]];
            rd_vld_reg   <= vld_reg[rd_frame[SLOT_W-1:0]];
            rd_frame_reg <= rd_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            peer_reg   <= '0;
            recv_reg   <= '0;
            sent_reg   <= '0;
            idx_reg    <= '0;
            count_reg  <= '0;
            err_reg    <= 1'b0;
        end else begin
            if (cmd.exec) begin
                if (item_reg.action == ACT_RECORD ||
                    (item_reg.action == ACT_SEND && !sts.send_abort)) begin
                    vld_reg[slot] <= 1'b1;
                    if (frame > newest_reg || newest_reg == 0) newest_reg <= frame;
                    oldest_reg <= oldest_upd;
                end
                if (item_reg.action == ACT_RECEIVE && rstat == ST_OK) begin
                    if (item_reg.pkt_last_confirmed > peer_reg)
                        peer_reg <= item_reg.pkt_last_confirmed;
                    if (item_reg.pkt_frame > recv_reg) recv_reg <= item_reg.pkt_frame;
                end
                idx_reg   <= '0;
                count_reg <= '0;
                err_reg   <= 1'b0;
            end
            if (cmd.plan) begin
                count_reg <= cnt_c;
                err_reg   <= need > {2'd0, buffer_bytes};
                if (need <= {2'd0, buffer_bytes}) sent_reg <= frame;
            end
            if (cmd.adv) idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // result build: header, report or answer on head, one ring word on word
    always_comb begin
        res_next = '0;
        if (cmd.head) begin
            unique case (item_reg.action)
                ACT_SEND: begin
                    res_next.kind      = KIND_HEADER;
                    res_next.frame_out = frame;
                    res_next.last      = 1'b1;
                    if (sts.send_abort || err_reg) begin
                        res_next.status = ST_BUF_SMALL;
                    end else begin
                        res_next.confirm_out = recv_reg;
                        res_next.count_out   = 8'(count_reg);
                        res_next.session_out = session_tag;
                        res_next.desync_out  = item_reg.desync_byte;
                        res_next.timing_out  = item_reg.timing_value;
                        res_next.last        = count_reg == 0;
                    end
                end
                ACT_RECEIVE: begin
                    res_next.kind   = KIND_REPORT;
                    res_next.status = rstat;
                    res_next.last   = 1'b1;
                    if (rstat == ST_OK) begin
                        res_next.frame_out   = item_reg.pkt_frame
                                               - {24'd0, item_reg.pkt_input_count} + 32'd1;
                        res_next.confirm_out = item_reg.pkt_last_confirmed;
                        res_next.count_out   = item_reg.pkt_input_count;
                    end
                end
                ACT_QUERY: begin
                    res_next.kind           = KIND_ANSWER;
                    res_next.confirmed_flag = frame <= peer_reg;
                    res_next.last           = 1'b1;
                end
                default: res_next.last = 1'b1;
            endcase
        end else begin
            res_next.kind = KIND_WORD;
            res_next.last = idx_reg == count_reg;
            if (rd_frame_reg < oldest_reg || rd_frame_reg > newest_reg ||
                !rd_vld_reg || rd_tag_reg != rd_frame_reg)
                res_next.word_out = item_reg.input_word;
            else
                res_next.word_out = rd_word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= in_item;
        if (cmd.exec) start_reg <= start_c;   // uses oldest after this record
        if (cmd.head || cmd.word) res <= res_next;
    end

endmodule

>>> design/crs_controller.sv
// Controller: sequences one item through record, plan, header and word results.
module crs_controller import crs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  crs_sts_t sts,
    output crs_cmd_t cmd
);

    crs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.action == ACT_RECORD) state_next = S_IDLE;
                else if (sts.action == ACT_SEND && !sts.send_abort) state_next = S_PLAN;
                else begin
                    cmd.head   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                // builds the send header once the plan is done
                cmd.head   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (sts.action == ACT_SEND && !sts.send_abort && !sts.send_err &&
                        sts.more) begin
                        cmd.rd     = 1'b1;
                        cmd.adv    = 1'b1;
                        state_next = S_WORD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WORD: begin
                cmd.word   = 1'b1;
                state_next = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> design/cumulative_redundant_input_sender.sv
// Top level: cumulative redundant input sender with stream and configuration ports.
//
// Input channel s_axis_*: one transaction per item; s_axis_tuser holds the action,
// s_axis_tdata the remaining fields packed from bit 0. Result channel m_axis_*:
// each item yields zero or more result transactions, the final one with tlast.
// Configuration channel cfg_*: index 0 session, 1 buffer bytes, 2 magic, 3 phase;
// write only while the block is idle.
// Sequence: a record yields nothing. Receive and query give one result, built
// in the execute state. A send gives its header after the plan state, then its
// words one by one: each word waits on a registered read of the history ring
// (read issued as the previous result is taken, word built in S_WORD). One item
// is processed at a time; s_axis_tready is high only while idle, from the cycle
// after the final result is taken.
// Reset (aresetn low, synchronous) clears the marks, the ring's valid bits and
// the controller; configuration returns to its reset values.
// A stall on m_axis_tready holds the current result and the whole sequence.
module cumulative_redundant_input_sender import crs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // frame_number, input_word, desync_byte, timing_value, pkt_magic, pkt_phase,
    // pkt_frame, pkt_last_confirmed, pkt_input_count, pkt_length, zero pad
    input  logic [223:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, frame_out, confirm_out, count_out, word_out, session_out,
    // desync_out, timing_out, confirmed_flag, zero pad
    output logic [151:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    crs_cmd_t cmd;
    crs_sts_t sts;
    crs_in_t  in_item;
    crs_out_t res;
    logic [15:0] session_reg, buffer_reg;
    logic [31:0] magic_reg;
    logic [7:0]  phase_reg;
    logic        in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg <= '0;
            buffer_reg  <= 16'd1500;
            magic_reg   <= '0;
            phase_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SESSION: session_reg <= cfg_data[15:0];
                REG_BUFFER:  buffer_reg  <= cfg_data[15:0];
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_PHASE:   phase_reg   <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // unpack the input transaction
    assign in_item.action             = s_axis_tuser;
    assign in_item.frame_number       = s_axis_tdata[31:0];
    assign in_item.input_word         = s_axis_tdata[47:32];
    assign in_item.desync_byte        = s_axis_tdata[55:48];
    assign in_item.timing_value       = s_axis_tdata[87:56];
    assign in_item.pkt_magic          = s_axis_tdata[119:88];
    assign in_item.pkt_phase          = s_axis_tdata[127:120];
    assign in_item.pkt_frame          = s_axis_tdata[159:128];
    assign in_item.pkt_last_confirmed = s_axis_tdata[191:160];
    assign in_item.pkt_input_count    = s_axis_tdata[199:192];
    assign in_item.pkt_length         = s_axis_tdata[215:200];

    crs_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    crs_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_item        (in_item),
        .session_tag    (session_reg),
        .buffer_bytes   (buffer_reg),
        .expected_magic (magic_reg),
        .gameplay_phase (phase_reg),
        .res            (res)
    );

    // pack the result transaction
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {4'd0, res.confirmed_flag, res.timing_out, res.desync_out,
                           res.session_out, res.word_out, res.count_out,
                           res.confirm_out, res.frame_out, res.status};

    // no new item while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // a word result never carries an error status
    a_word_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_WORD) |-> res.status == ST_OK)
        else $error("word result with error status");

    // an accepted item always starts execution next cycle
    a_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> cmd.exec)
        else $error("accepted item not executed");

endmodule

>>> tb/testbench.sv
// Testbench for the cumulative redundant input sender: stream driver, monitor and predictor.
module testbench;
    import crs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_WAIT   = 80;    // idle time after the last result of a drain
    localparam int STALL_LIMIT = 3000;  // cycles with no transaction at all

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = ACT_RECORD;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b1;
    logic [151:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = REG_SESSION;
    logic [31:0]  cfg_data = '0;

    cumulative_redundant_input_sender u_top (.*);

    always #5 aclk = ~aclk;

    // Predictor state: configuration and history as the block should hold them.
    logic [15:0] cfg_session = 16'd0;
    logic [15:0] cfg_buffer  = 16'd1500;
    logic [31:0] cfg_magic   = 32'd0;
    logic [7:0]  cfg_phase   = 8'd0;
    logic [15:0] ring_words [HISTORY_DEPTH];
    logic [31:0] ring_tags  [HISTORY_DEPTH];
    logic [31:0] ring_newest = '0, ring_oldest = '0, peer_confirm = '0, recv_mark = '0;

    crs_in_t  item_q[$];       // items waiting for the driver
    crs_out_t expected_q[$];   // results the block still owes
    crs_in_t  s_item;
    logic     no_gaps = 1'b0;  // burst mode: no idling on either side
    int       gap_left = 0;
    int       stall_left = 0;
    int       mismatches = 0;
    int       items_sent = 0, results_seen = 0, sends_seen = 0, reports_seen = 0;
    int       quiet_cycles = 0;

    initial begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring_words[i] = '0;
            ring_tags[i]  = '0;
        end
    end

    function automatic void keep_word(input logic [31:0] frame, input logic [15:0] w);
        ring_words[frame % HISTORY_DEPTH] = w;
        ring_tags[frame % HISTORY_DEPTH]  = frame;
        if (frame > ring_newest || ring_newest == 0) ring_newest = frame;
        if (ring_oldest == 0) ring_oldest = frame;
        else if (frame >= HISTORY_DEPTH) ring_oldest = frame - HISTORY_DEPTH + 1;
    endfunction

    function automatic logic [15:0] held_word(input logic [31:0] frame,
                                              input logic [15:0] fallback);
        if (frame < ring_oldest || frame > ring_newest) return fallback;
        if (ring_tags[frame % HISTORY_DEPTH] != frame) return fallback;
        return ring_words[frame % HISTORY_DEPTH];
    endfunction

    // Work out what one accepted item must produce and queue it.
    function automatic void forecast_results(input crs_in_t it);
        crs_out_t r;
        logic [31:0] start;
        longint unsigned cnt;
        logic [2:0] st;
        r = '0;
        case (it.action)
            ACT_RECORD: keep_word(it.frame_number, it.input_word);
            ACT_SEND: begin
                r.kind = KIND_HEADER;
                r.frame_out = it.frame_number;
                r.last = 1'b1;
                if (cfg_buffer < HEADER_BYTES) begin
                    r.status = ST_BUF_SMALL;
                    expected_q.push_back(r);
                end else begin
                    keep_word(it.frame_number, it.input_word);
                    start = peer_confirm + 1;
                    if (start < 1) start = 1;
                    if (start < ring_oldest) start = ring_oldest;
                    cnt = (it.frame_number >= start) ?
                          longint'(it.frame_number) - longint'(start) + 1 : 0;
                    if (cnt > MAX_INPUTS) cnt = MAX_INPUTS;
                    if (HEADER_BYTES + 2 * cnt > cfg_buffer) begin
                        r.status = ST_BUF_SMALL;
                        expected_q.push_back(r);
                    end else begin
                        r.confirm_out = recv_mark;
                        r.count_out   = cnt[7:0];
                        r.session_out = cfg_session;
                        r.desync_out  = it.desync_byte;
                        r.timing_out  = it.timing_value;
                        r.last        = (cnt == 0);
                        expected_q.push_back(r);
                        for (int i = 0; i < cnt; i++) begin
                            r = '0;
                            r.kind = KIND_WORD;
                            r.word_out = held_word(it.frame_number - i, it.input_word);
                            r.last = (i + 1 == cnt);
                            expected_q.push_back(r);
                        end
                        sends_seen++;
                    end
                end
            end
            ACT_RECEIVE: begin
                r.kind = KIND_REPORT;
                r.last = 1'b1;
                if (it.pkt_length < HEADER_BYTES) st = ST_SHORT;
                else if (it.pkt_magic != cfg_magic) st = ST_BAD_MAGIC;
                else if (it.pkt_phase != cfg_phase) st = ST_BAD_PHASE;
                else if (it.pkt_length < HEADER_BYTES + 2 * it.pkt_input_count) st = ST_SHORT;
                else if (it.pkt_input_count > MAX_INPUTS) st = ST_TOO_MANY;
                else st = ST_OK;
                r.status = st;
                if (st == ST_OK) begin
                    r.frame_out   = it.pkt_frame - it.pkt_input_count + 1;
                    r.confirm_out = it.pkt_last_confirmed;
                    r.count_out   = it.pkt_input_count;
                    if (it.pkt_last_confirmed > peer_confirm) peer_confirm = it.pkt_last_confirmed;
                    if (it.pkt_frame > recv_mark) recv_mark = it.pkt_frame;
                end
                expected_q.push_back(r);
                reports_seen++;
            end
            default: begin
                r.kind = KIND_ANSWER;
                r.confirmed_flag = (it.frame_number <= peer_confirm);
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endcase
    endfunction

    // Driver: present queued items, random gap after each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                forecast_results(s_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    s_item = item_q.pop_front();
                    s_axis_tuser <= s_item.action;
                    s_axis_tdata <= {8'h00, s_item.pkt_length, s_item.pkt_input_count,
                                     s_item.pkt_last_confirmed, s_item.pkt_frame,
                                     s_item.pkt_phase, s_item.pkt_magic, s_item.timing_value,
                                     s_item.desync_byte, s_item.input_word,
                                     s_item.frame_number};
                    s_axis_tvalid <= 1'b1;
                    gap_left <= no_gaps ? 0 : $urandom_range(0, 4);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result against the oldest expectation, stall at random.
    always @(posedge aclk) begin
        crs_out_t got, want;
        int draw;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind           = m_axis_tuser;
                got.status         = m_axis_tdata[2:0];
                got.frame_out      = m_axis_tdata[34:3];
                got.confirm_out    = m_axis_tdata[66:35];
                got.count_out      = m_axis_tdata[74:67];
                got.word_out       = m_axis_tdata[90:75];
                got.session_out    = m_axis_tdata[106:91];
                got.desync_out     = m_axis_tdata[114:107];
                got.timing_out     = m_axis_tdata[146:115];
                got.confirmed_flag = m_axis_tdata[147];
                got.last           = m_axis_tlast;
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
                draw = no_gaps ? 0 : $urandom_range(0, 4);
                m_axis_tready <= (draw == 0);
                stall_left <= draw;
            end else if (!m_axis_tready) begin
                if (stall_left <= 1) m_axis_tready <= 1'b1;
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog: give up when nothing moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SESSION: cfg_session = value[15:0];
            REG_BUFFER:  cfg_buffer  = value[15:0];
            REG_MAGIC:   cfg_magic   = value;
            default:     cfg_phase   = value[7:0];
        endcase
    endtask

    // Hold until every queued item is taken and every result has arrived.
    task automatic drain();
        do @(posedge aclk);
        while (item_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    function automatic crs_in_t blank_item(input logic [1:0] act, input logic [31:0] frame);
        crs_in_t it;
        it.action             = act;
        it.frame_number       = frame;
        it.input_word         = 16'($urandom);
        it.desync_byte        = 8'($urandom);
        it.timing_value       = $urandom;
        it.pkt_magic          = $urandom;
        it.pkt_phase          = 8'($urandom);
        it.pkt_frame          = $urandom;
        it.pkt_last_confirmed = $urandom;
        it.pkt_input_count    = 8'($urandom);
        it.pkt_length         = 16'($urandom);
        return it;
    endfunction

    function automatic crs_in_t good_packet(input logic [31:0] frame, input int cnt,
                                            input logic [31:0] conf);
        crs_in_t it;
        it = blank_item(ACT_RECEIVE, 0);
        it.pkt_magic          = cfg_magic;
        it.pkt_phase          = cfg_phase;
        it.pkt_frame          = frame;
        it.pkt_last_confirmed = conf;
        it.pkt_input_count    = 8'(cnt);
        it.pkt_length         = 16'(HEADER_BYTES + 2 * cnt + $urandom_range(0, 3));
        return it;
    endfunction

    // Well-formed traffic around a running local frame, with some noise mixed in.
    task automatic random_traffic(input int n, inout logic [31:0] frame);
        crs_in_t it;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) frame = frame + $urandom_range(2, 140);
            if (pick < 35) begin
                frame = frame + 1;
                it = blank_item(ACT_RECORD, frame);
            end else if (pick < 62) begin
                frame = frame + 1;
                it = blank_item(ACT_SEND, frame);
            end else if (pick < 82) begin
                it = good_packet(frame + $urandom_range(0, 3), $urandom_range(0, MAX_INPUTS),
                                 frame - $urandom_range(0, 40));
            end else if (pick < 90) begin
                it = blank_item(ACT_RECEIVE, $urandom);
                if ($urandom_range(0, 1)) begin
                    it.pkt_magic = cfg_magic;
                    it.pkt_phase = cfg_phase;
                end
            end else if (pick < 97) begin
                it = blank_item(ACT_QUERY, frame - $urandom_range(0, 40));
            end else begin
                it = blank_item(ACT_QUERY, $urandom);
            end
            item_q.push_back(it);
            if (k % 30 == 29) drain();  // let the sender go quiet mid-stream
        end
    endtask

    initial begin
        crs_in_t it;
        logic [31:0] frame;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: defaults are magic 0, phase 0, 1500-byte buffer.
        item_q.push_back(blank_item(ACT_QUERY, 32'd0));          // frame zero counts as confirmed
        item_q.push_back(blank_item(ACT_SEND, 32'd0));           // empty send, header only
        for (int f = 1; f <= 5; f++) item_q.push_back(blank_item(ACT_RECORD, f));
        item_q.push_back(blank_item(ACT_SEND, 32'd7));           // frame 6 missing, falls back
        item_q.push_back(good_packet(32'd6, 3, 32'd3));
        it = good_packet(32'd9, 0, 32'd0); it.pkt_length = 16'd23;
        item_q.push_back(it);                                    // shorter than a header
        it = good_packet(32'd9, 1, 32'd0); it.pkt_magic = 32'hFFFF_FFFF;
        item_q.push_back(it);                                    // wrong magic
        it = good_packet(32'd9, 1, 32'd0); it.pkt_phase = 8'hFF;
        item_q.push_back(it);                                    // wrong phase
        it = good_packet(32'd9, 4, 32'd0); it.pkt_length = 16'd31;
        item_q.push_back(it);                                    // too short for its words
        it = good_packet(32'd9, 33, 32'd0); it.pkt_length = 16'hFFFF;
        item_q.push_back(it);                                    // one word too many
        it = good_packet(32'd9, 255, 32'd0); it.pkt_length = 16'hFFFF;
        item_q.push_back(it);
        item_q.push_back(blank_item(ACT_QUERY, 32'd3));
        item_q.push_back(blank_item(ACT_QUERY, 32'd4));
        item_q.push_back(blank_item(ACT_SEND, 32'd100));         // capped at the word limit
        item_q.push_back(blank_item(ACT_RECORD, 32'd300));       // wraps the ring
        item_q.push_back(blank_item(ACT_SEND, 32'd310));
        item_q.push_back(good_packet(32'hFFFF_FFFF, 32, 32'hFFFF_FFFF)); // confirm start wraps
        item_q.push_back(blank_item(ACT_SEND, 32'hFFFF_FFFF));
        item_q.push_back(blank_item(ACT_QUERY, 32'hFFFF_FFFF));
        drain();

        // Random phase with fresh settings and full-range tags.
        write_reg(REG_SESSION, $urandom);
        write_reg(REG_MAGIC, $urandom);
        write_reg(REG_PHASE, $urandom);
        write_reg(REG_BUFFER, 32'd1500);
        frame = 32'd1;
        random_traffic(40, frame);
        drain();

        // Buffer extremes: below a header, header only, a few words.
        write_reg(REG_BUFFER, 32'd0);
        item_q.push_back(blank_item(ACT_SEND, frame + 1));
        item_q.push_back(blank_item(ACT_SEND, frame + 2));
        drain();
        write_reg(REG_BUFFER, 32'd24);
        item_q.push_back(blank_item(ACT_SEND, frame + 3));
        drain();
        write_reg(REG_BUFFER, 32'd30);
        random_traffic(15, frame);
        drain();

        // Opposite extremes of every register, burst mode without idling.
        write_reg(REG_SESSION, 32'h0000_FFFF);
        write_reg(REG_BUFFER, 32'h0000_FFFF);
        write_reg(REG_MAGIC, 32'hFFFF_FFFF);
        write_reg(REG_PHASE, 32'h0000_00FF);
        no_gaps = 1'b1;
        random_traffic(15, frame);
        drain();
        no_gaps = 1'b0;
        frame = 32'hFFFF_FF80;
        random_traffic(15, frame);
        drain();

        $display("covered %0d items: %0d full sends, %0d receive reports, %0d results checked",
                 items_sent, sends_seen, reports_seen, results_seen);
        $display("mismatches: %0d, results still owed: %0d", mismatches, expected_q.size());
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
